@@ rtl/qvr_pkg.sv @@
// Shared constants for the quaternion vector rotation pipeline.
// No dependencies; imported by the channel interfaces and every module.
package qvr_pkg;

   // Default width of the integer vector components
   localparam int QVR_VEC_WIDTH      = 16;
   // Default fraction bits of the quaternion components
   localparam int QVR_QUAT_FRAC_BITS = 14;
   // Quaternion component width (Q2.14 at the default)
   localparam int QVR_QUAT_WIDTH     = 16;
   // Width of the rotated, saturated result components
   localparam int QVR_OUT_WIDTH      = 18;
   // Accumulator width used for wrap-around and rounding
   localparam int QVR_ACC_WIDTH      = 64;
   // Saturation limits of the result components
   localparam int QVR_OUT_MAX        = (2 ** (QVR_OUT_WIDTH - 1)) - 1;
   localparam int QVR_OUT_MIN        = -(2 ** (QVR_OUT_WIDTH - 1));

endpackage

@@ rtl/qvr_if.sv @@
// Valid/ready channel interfaces for request and response items.
// Depends on qvr_pkg for the field widths.

// Request channel: vector plus quaternion
interface qvr_req_if import qvr_pkg::*; #(
   parameter int VEC_WIDTH = QVR_VEC_WIDTH
) ();
   logic                             valid;
   logic                             ready;
   logic signed [VEC_WIDTH-1:0]      vec_x;
   logic signed [VEC_WIDTH-1:0]      vec_y;
   logic signed [VEC_WIDTH-1:0]      vec_z;
   logic signed [QVR_QUAT_WIDTH-1:0] quat_x;
   logic signed [QVR_QUAT_WIDTH-1:0] quat_y;
   logic signed [QVR_QUAT_WIDTH-1:0] quat_z;
   logic signed [QVR_QUAT_WIDTH-1:0] quat_w;

   modport source (
      output valid, vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w,
      input  ready
   );
   modport sink (
      input  valid, vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w,
      output ready
   );
endinterface

// Response channel: rotated vector and clamp flag
interface qvr_rsp_if import qvr_pkg::*; ();
   logic                            valid;
   logic                            ready;
   logic signed [QVR_OUT_WIDTH-1:0] rot_x;
   logic signed [QVR_OUT_WIDTH-1:0] rot_y;
   logic signed [QVR_OUT_WIDTH-1:0] rot_z;
   logic                            saturated;

   modport source (
      output valid, rot_x, rot_y, rot_z, saturated,
      input  ready
   );
   modport sink (
      input  valid, rot_x, rot_y, rot_z, saturated,
      output ready
   );
endinterface

@@ rtl/qvr_qv_mul.sv @@
// First Hamilton product p = q * (v, 0), two register stages:
// twelve partial products, then the four exact sums. Depends on qvr_pkg.
module qvr_qv_mul import qvr_pkg::*; #(
   parameter int VEC_WIDTH = QVR_VEC_WIDTH,
   localparam int MW = VEC_WIDTH + QVR_QUAT_WIDTH,
   localparam int PW = MW + 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [VEC_WIDTH-1:0]      vec_x,
   input  logic signed [VEC_WIDTH-1:0]      vec_y,
   input  logic signed [VEC_WIDTH-1:0]      vec_z,
   input  logic signed [QVR_QUAT_WIDTH-1:0] quat_x,
   input  logic signed [QVR_QUAT_WIDTH-1:0] quat_y,
   input  logic signed [QVR_QUAT_WIDTH-1:0] quat_z,
   input  logic signed [QVR_QUAT_WIDTH-1:0] quat_w,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [PW-1:0]             p_x,
   output logic signed [PW-1:0]             p_y,
   output logic signed [PW-1:0]             p_z,
   output logic signed [PW-1:0]             p_w,
   output logic signed [QVR_QUAT_WIDTH-1:0] q_x,
   output logic signed [QVR_QUAT_WIDTH-1:0] q_y,
   output logic signed [QVR_QUAT_WIDTH-1:0] q_z,
   output logic signed [QVR_QUAT_WIDTH-1:0] q_w
);

   // stage valids and enables
   logic v1_ff, v2_ff;
   logic en1, en2;

   // stage 1: products, named m_<quat><vec>
   logic signed [MW-1:0] m_wx_ff, m_wy_ff, m_wz_ff;
   logic signed [MW-1:0] m_xx_ff, m_xy_ff, m_xz_ff;
   logic signed [MW-1:0] m_yx_ff, m_yy_ff, m_yz_ff;
   logic signed [MW-1:0] m_zx_ff, m_zy_ff, m_zz_ff;
   logic signed [QVR_QUAT_WIDTH-1:0] q1_x_ff, q1_y_ff, q1_z_ff, q1_w_ff;

   // stage 2: sums
   logic signed [PW-1:0] p_x_ff, p_y_ff, p_z_ff, p_w_ff;
   logic signed [PW-1:0] p_x_in, p_y_in, p_z_in, p_w_in;
   logic signed [QVR_QUAT_WIDTH-1:0] q2_x_ff, q2_y_ff, q2_z_ff, q2_w_ff;

   // a stage moves when it is empty or the next one takes its item
   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   // partial products
   always_ff @(posedge clock) begin
      if (en1) begin
         m_wx_ff <= quat_w * vec_x;
         m_wy_ff <= quat_w * vec_y;
         m_wz_ff <= quat_w * vec_z;
         m_xx_ff <= quat_x * vec_x;
         m_xy_ff <= quat_x * vec_y;
         m_xz_ff <= quat_x * vec_z;
         m_yx_ff <= quat_y * vec_x;
         m_yy_ff <= quat_y * vec_y;
         m_yz_ff <= quat_y * vec_z;
         m_zx_ff <= quat_z * vec_x;
         m_zy_ff <= quat_z * vec_y;
         m_zz_ff <= quat_z * vec_z;
         q1_x_ff <= quat_x;
         q1_y_ff <= quat_y;
         q1_z_ff <= quat_z;
         q1_w_ff <= quat_w;
      end
   end

   // exact sums of q * (v, 0)
   always_comb begin
      p_x_in = m_wx_ff - m_zy_ff + m_yz_ff;
      p_y_in = m_zx_ff + m_wy_ff - m_xz_ff;
      p_z_in = m_xy_ff - m_yx_ff + m_wz_ff;
      p_w_in = -m_xx_ff - m_yy_ff - m_zz_ff;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         p_x_ff  <= p_x_in;
         p_y_ff  <= p_y_in;
         p_z_ff  <= p_z_in;
         p_w_ff  <= p_w_in;
         q2_x_ff <= q1_x_ff;
         q2_y_ff <= q1_y_ff;
         q2_z_ff <= q1_z_ff;
         q2_w_ff <= q1_w_ff;
      end
   end

   assign out_valid = v2_ff;
   assign p_x = p_x_ff;
   assign p_y = p_y_ff;
   assign p_z = p_z_ff;
   assign p_w = p_w_ff;
   assign q_x = q2_x_ff;
   assign q_y = q2_y_ff;
   assign q_z = q2_z_ff;
   assign q_w = q2_w_ff;

endmodule

@@ rtl/qvr_pq_mul.sv @@
// Second Hamilton product r = p * conj(q), vector part only, two register
// stages: twelve partial products, then the sums. Depends on qvr_pkg.
module qvr_pq_mul import qvr_pkg::*; #(
   parameter int VEC_WIDTH = QVR_VEC_WIDTH,
   localparam int PW  = VEC_WIDTH + QVR_QUAT_WIDTH + 2,
   localparam int PQW = PW + QVR_QUAT_WIDTH,
   localparam int SW  = PQW + 2,
   localparam int RW  = (SW > QVR_ACC_WIDTH) ? QVR_ACC_WIDTH : SW
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [PW-1:0]             p_x,
   input  logic signed [PW-1:0]             p_y,
   input  logic signed [PW-1:0]             p_z,
   input  logic signed [PW-1:0]             p_w,
   input  logic signed [QVR_QUAT_WIDTH-1:0] q_x,
   input  logic signed [QVR_QUAT_WIDTH-1:0] q_y,
   input  logic signed [QVR_QUAT_WIDTH-1:0] q_z,
   input  logic signed [QVR_QUAT_WIDTH-1:0] q_w,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [RW-1:0]             r_x,
   output logic signed [RW-1:0]             r_y,
   output logic signed [RW-1:0]             r_z
);

   logic v1_ff, v2_ff;
   logic en1, en2;

   // stage 1: products, named m_<p><q>
   logic signed [PQW-1:0] m_xw_ff, m_wx_ff, m_zy_ff, m_yz_ff;
   logic signed [PQW-1:0] m_yw_ff, m_zx_ff, m_wy_ff, m_xz_ff;
   logic signed [PQW-1:0] m_zw_ff, m_yx_ff, m_xy_ff, m_wz_ff;

   // stage 2: sums, wrapped to the accumulator width
   logic signed [SW-1:0] s_x, s_y, s_z;
   logic signed [RW-1:0] r_x_ff, r_y_ff, r_z_ff;

   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   // partial products
   always_ff @(posedge clock) begin
      if (en1) begin
         m_xw_ff <= p_x * q_w;
         m_wx_ff <= p_w * q_x;
         m_zy_ff <= p_z * q_y;
         m_yz_ff <= p_y * q_z;
         m_yw_ff <= p_y * q_w;
         m_zx_ff <= p_z * q_x;
         m_wy_ff <= p_w * q_y;
         m_xz_ff <= p_x * q_z;
         m_zw_ff <= p_z * q_w;
         m_yx_ff <= p_y * q_x;
         m_xy_ff <= p_x * q_y;
         m_wz_ff <= p_w * q_z;
      end
   end

   // conj(q) = (-x, -y, -z, w) folded into the signs
   always_comb begin
      s_x = m_xw_ff - m_wx_ff + m_zy_ff - m_yz_ff;
      s_y = m_yw_ff - m_zx_ff - m_wy_ff + m_xz_ff;
      s_z = m_zw_ff + m_yx_ff - m_xy_ff - m_wz_ff;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         r_x_ff <= s_x[RW-1:0];
         r_y_ff <= s_y[RW-1:0];
         r_z_ff <= s_z[RW-1:0];
      end
   end

   assign out_valid = v2_ff;
   assign r_x = r_x_ff;
   assign r_y = r_y_ff;
   assign r_z = r_z_ff;

endmodule

@@ rtl/qvr_round_sat.sv @@
// Round-to-nearest and saturation of the rotated vector; this stage is
// the response output register. Depends on qvr_pkg.
module qvr_round_sat import qvr_pkg::*; #(
   parameter int RW             = QVR_ACC_WIDTH,
   parameter int QUAT_FRAC_BITS = QVR_QUAT_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [RW-1:0]            r_x,
   input  logic signed [RW-1:0]            r_y,
   input  logic signed [RW-1:0]            r_z,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic signed [QVR_OUT_WIDTH-1:0] rot_x,
   output logic signed [QVR_OUT_WIDTH-1:0] rot_y,
   output logic signed [QVR_OUT_WIDTH-1:0] rot_z,
   output logic                            saturated
);

   localparam int SHIFT = 2 * QUAT_FRAC_BITS;
   localparam logic [QVR_ACC_WIDTH-1:0] ROUND_BIAS =
      QVR_ACC_WIDTH'(1) << (SHIFT - 1);
   localparam logic signed [QVR_ACC_WIDTH-1:0] SAT_MAX = QVR_ACC_WIDTH'(QVR_OUT_MAX);
   localparam logic signed [QVR_ACC_WIDTH-1:0] SAT_MIN = QVR_ACC_WIDTH'(QVR_OUT_MIN);

   // returns {clamped, value}
   function automatic logic [QVR_OUT_WIDTH:0] round_sat(input logic signed [RW-1:0] acc);
      logic signed [QVR_ACC_WIDTH-1:0] biased;
      logic signed [QVR_ACC_WIDTH-1:0] shifted;
      logic [QVR_OUT_WIDTH:0]          res;
      biased  = QVR_ACC_WIDTH'(acc) + ROUND_BIAS;
      shifted = biased >>> SHIFT;
      if (shifted > SAT_MAX) begin
         res = {1'b1, SAT_MAX[QVR_OUT_WIDTH-1:0]};
      end else if (shifted < SAT_MIN) begin
         res = {1'b1, SAT_MIN[QVR_OUT_WIDTH-1:0]};
      end else begin
         res = {1'b0, shifted[QVR_OUT_WIDTH-1:0]};
      end
      return res;
   endfunction

   logic                            v_ff;
   logic                            en;
   logic [QVR_OUT_WIDTH:0]          sx, sy, sz;
   logic signed [QVR_OUT_WIDTH-1:0] rot_x_ff, rot_y_ff, rot_z_ff;
   logic                            sat_ff;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   // per-component round and clamp
   always_comb begin
      sx = round_sat(r_x);
      sy = round_sat(r_y);
      sz = round_sat(r_z);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_x_ff <= sx[QVR_OUT_WIDTH-1:0];
         rot_y_ff <= sy[QVR_OUT_WIDTH-1:0];
         rot_z_ff <= sz[QVR_OUT_WIDTH-1:0];
         sat_ff   <= sx[QVR_OUT_WIDTH] | sy[QVR_OUT_WIDTH] | sz[QVR_OUT_WIDTH];
      end
   end

   assign out_valid = v_ff;
   assign rot_x     = rot_x_ff;
   assign rot_y     = rot_y_ff;
   assign rot_z     = rot_z_ff;
   assign saturated = sat_ff;

endmodule

@@ rtl/quaternion_vector_rotate.sv @@
// Quaternion vector rotation r = q * (v, 0) * conj(q), five-stage pipeline.
// Registers from request accept to response valid: the two multiply/sum
// pairs and the round/saturate output register.
// Throughput: one item per cycle; a stalled response holds its item while
// empty stages upstream keep filling. Reset clears every stage valid bit.
module quaternion_vector_rotate import qvr_pkg::*; #(
   parameter int VEC_WIDTH      = QVR_VEC_WIDTH,
   parameter int QUAT_FRAC_BITS = QVR_QUAT_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   qvr_req_if.sink    req_if,
   qvr_rsp_if.source  rsp_if
);

   localparam int PW         = VEC_WIDTH + QVR_QUAT_WIDTH + 2;
   localparam int SW         = PW + QVR_QUAT_WIDTH + 2;
   localparam int RW         = (SW > QVR_ACC_WIDTH) ? QVR_ACC_WIDTH : SW;
   localparam int PIPE_DEPTH = 5;
   localparam int CNT_WIDTH  = $clog2(PIPE_DEPTH + 1);

   // p = q * (v, 0) to second product
   logic                             p_valid, p_ready;
   logic signed [PW-1:0]             p_x, p_y, p_z, p_w;
   logic signed [QVR_QUAT_WIDTH-1:0] q_x, q_y, q_z, q_w;

   // r to rounding stage
   logic                 r_valid, r_ready;
   logic signed [RW-1:0] r_x, r_y, r_z;

   qvr_qv_mul #(
      .VEC_WIDTH (VEC_WIDTH)
   ) u_qv_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .vec_x     (req_if.vec_x),
      .vec_y     (req_if.vec_y),
      .vec_z     (req_if.vec_z),
      .quat_x    (req_if.quat_x),
      .quat_y    (req_if.quat_y),
      .quat_z    (req_if.quat_z),
      .quat_w    (req_if.quat_w),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .p_x       (p_x),
      .p_y       (p_y),
      .p_z       (p_z),
      .p_w       (p_w),
      .q_x       (q_x),
      .q_y       (q_y),
      .q_z       (q_z),
      .q_w       (q_w)
   );

   qvr_pq_mul #(
      .VEC_WIDTH (VEC_WIDTH)
   ) u_pq_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .p_x       (p_x),
      .p_y       (p_y),
      .p_z       (p_z),
      .p_w       (p_w),
      .q_x       (q_x),
      .q_y       (q_y),
      .q_z       (q_z),
      .q_w       (q_w),
      .out_valid (r_valid),
      .out_ready (r_ready),
      .r_x       (r_x),
      .r_y       (r_y),
      .r_z       (r_z)
   );

   qvr_round_sat #(
      .RW             (RW),
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
   ) u_round_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r_valid),
      .in_ready  (r_ready),
      .r_x       (r_x),
      .r_y       (r_y),
      .r_z       (r_z),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .rot_x     (rsp_if.rot_x),
      .rot_y     (rsp_if.rot_y),
      .rot_z     (rsp_if.rot_z),
      .saturated (rsp_if.saturated)
   );

   // items in flight, for the checks below
   logic                 req_fire, rsp_fire;
   logic [CNT_WIDTH-1:0] inflight_ff, inflight_in;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_if.valid && rsp_if.ready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_fire && !rsp_fire) begin
         inflight_in = inflight_ff + CNT_WIDTH'(1);
      end else if (rsp_fire && !req_fire) begin
         inflight_in = inflight_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // the pipeline never holds more items than it has stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_WIDTH'(PIPE_DEPTH))
      else $error("pipeline holds more items than stages");

   // a response is only offered for an item that was accepted
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> inflight_ff != '0)
      else $error("response offered with no item in flight");

   // a full pipeline with a stalled response must stall the request side
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == CNT_WIDTH'(PIPE_DEPTH)) && !rsp_if.ready |-> !req_if.ready)
      else $error("request taken while pipeline full and stalled");

   // reset empties every stage
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid && inflight_ff == '0)
      else $error("pipeline not empty after reset");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for quaternion_vector_rotate: directed and random items,
// each predicted in a scoreboard class and compared field by field with the response.
// Depends on qvr_pkg, qvr_if.sv and the quaternion_vector_rotate RTL.
module tb_top;
   import qvr_pkg::*;

   localparam int LIMIT_CYCLES = 500000;
   localparam int RANDOM_ITEMS = 1880;
   localparam int DRAIN_CYCLES = 12;   // drain margin past the five-stage pipeline

   typedef struct {
      logic signed [QVR_VEC_WIDTH-1:0]  vec_x;
      logic signed [QVR_VEC_WIDTH-1:0]  vec_y;
      logic signed [QVR_VEC_WIDTH-1:0]  vec_z;
      logic signed [QVR_QUAT_WIDTH-1:0] quat_x;
      logic signed [QVR_QUAT_WIDTH-1:0] quat_y;
      logic signed [QVR_QUAT_WIDTH-1:0] quat_z;
      logic signed [QVR_QUAT_WIDTH-1:0] quat_w;
   } rot_req_type;

   typedef struct {
      logic signed [QVR_OUT_WIDTH-1:0] rot_x;
      logic signed [QVR_OUT_WIDTH-1:0] rot_y;
      logic signed [QVR_OUT_WIDTH-1:0] rot_z;
      logic                            saturated;
   } rot_rsp_type;

   // Receiver behaviour, chosen at random for each stretch
   typedef enum logic [1:0] {RX_FLOW, RX_RANDOM, RX_PULSE, RX_SPARSE} rx_mode_type;

   // Expected rotations in acceptance order, checked against each response item
   class rotation_checker_type;
      rot_rsp_type expected_rot[$];
      int unsigned mismatches = 0;
      int unsigned reported   = 0;

      // Round to nearest (ties upward), then clamp to the output range
      function logic signed [QVR_OUT_WIDTH-1:0] round_clamp(input longint acc,
                                                            inout logic clamped);
         longint v;
         v = (acc + (longint'(1) << (2 * QVR_QUAT_FRAC_BITS - 1)))
             >>> (2 * QVR_QUAT_FRAC_BITS);
         if (v > QVR_OUT_MAX) begin
            v = QVR_OUT_MAX;
            clamped = 1'b1;
         end else if (v < QVR_OUT_MIN) begin
            v = QVR_OUT_MIN;
            clamped = 1'b1;
         end
         return v[QVR_OUT_WIDTH-1:0];
      endfunction

      // r = q * (v, 0) * conj(q), kept exact in 64 bits until the final rounding
      function rot_rsp_type rotate_vec(input rot_req_type r);
         longint      vx, vy, vz, qx, qy, qz, qw;
         longint      px, py, pz, pw, rx, ry, rz;
         logic        clamped;
         rot_rsp_type res;
         vx = r.vec_x;  vy = r.vec_y;  vz = r.vec_z;
         qx = r.quat_x; qy = r.quat_y; qz = r.quat_z; qw = r.quat_w;
         px =  qw * vx - qz * vy + qy * vz;
         py =  qz * vx + qw * vy - qx * vz;
         pz = -qy * vx + qx * vy + qw * vz;
         pw = -qx * vx - qy * vy - qz * vz;
         rx = px * qw - pw * qx + pz * qy - py * qz;
         ry = py * qw - pz * qx - pw * qy + px * qz;
         rz = pz * qw + py * qx - px * qy - pw * qz;
         clamped   = 1'b0;
         res.rot_x = round_clamp(rx, clamped);
         res.rot_y = round_clamp(ry, clamped);
         res.rot_z = round_clamp(rz, clamped);
         res.saturated = clamped;
         return res;
      endfunction

      function void note_request(input rot_req_type r);
         expected_rot.push_back(rotate_vec(r));
      endfunction

      function void flag(input string what, input longint want, input longint got);
         mismatches++;
         if (reported < 40) begin
            reported++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         end
      endfunction

      function void check_result(input rot_rsp_type got);
         rot_rsp_type want;
         if (expected_rot.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item rot=(%0d,%0d,%0d) sat=%0b", $time,
                     got.rot_x, got.rot_y, got.rot_z, got.saturated);
            return;
         end
         want = expected_rot.pop_front();
         if (got.rot_x !== want.rot_x) flag("rot_x", want.rot_x, got.rot_x);
         if (got.rot_y !== want.rot_y) flag("rot_y", want.rot_y, got.rot_y);
         if (got.rot_z !== want.rot_z) flag("rot_z", want.rot_z, got.rot_z);
         if (got.saturated !== want.saturated)
            flag("saturated", want.saturated, got.saturated);
      endfunction

      function int pending();
         return expected_rot.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   qvr_req_if #(.VEC_WIDTH(QVR_VEC_WIDTH)) req_if ();
   qvr_rsp_if                              rsp_if ();

   quaternion_vector_rotate #(
      .VEC_WIDTH      (QVR_VEC_WIDTH),
      .QUAT_FRAC_BITS (QVR_QUAT_FRAC_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   rotation_checker_type rot_check  = new();
   int unsigned          cycles     = 0;
   int                   burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("FAIL quaternion_vector_rotate");
         $finish;
      end
   end

   // Monitor both channels on every accepting edge
   always @(posedge clock) begin
      rot_req_type a;
      rot_rsp_type b;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            a.vec_x  = req_if.vec_x;  a.vec_y  = req_if.vec_y;  a.vec_z = req_if.vec_z;
            a.quat_x = req_if.quat_x; a.quat_y = req_if.quat_y;
            a.quat_z = req_if.quat_z; a.quat_w = req_if.quat_w;
            rot_check.note_request(a);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            b.rot_x = rsp_if.rot_x; b.rot_y = rsp_if.rot_y; b.rot_z = rsp_if.rot_z;
            b.saturated = rsp_if.saturated;
            rot_check.check_result(b);
         end
      end
   end

   // Receiver: back-pressure pattern of its own, including free-flowing stretches
   initial begin
      rx_mode_type mode;
      int unsigned mode_left;
      mode          = RX_FLOW;
      mode_left     = 0;
      rsp_if.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (mode)
            RX_FLOW:   rsp_if.ready <= 1'b1;
            RX_RANDOM: rsp_if.ready <= 1'($urandom_range(0, 1));
            RX_PULSE:  rsp_if.ready <= (mode_left % 4 == 0);
            default:   rsp_if.ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   function automatic rot_req_type make_req(input int vx, input int vy, input int vz,
                                            input int qx, input int qy, input int qz,
                                            input int qw);
      rot_req_type r;
      r.vec_x  = vx[QVR_VEC_WIDTH-1:0];
      r.vec_y  = vy[QVR_VEC_WIDTH-1:0];
      r.vec_z  = vz[QVR_VEC_WIDTH-1:0];
      r.quat_x = qx[QVR_QUAT_WIDTH-1:0];
      r.quat_y = qy[QVR_QUAT_WIDTH-1:0];
      r.quat_z = qz[QVR_QUAT_WIDTH-1:0];
      r.quat_w = qw[QVR_QUAT_WIDTH-1:0];
      return r;
   endfunction

   function automatic int srand(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   // Random item of one of several shapes
   function automatic rot_req_type random_req();
      int          kind;
      int          axis;
      int          q [4];
      rot_req_type r;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         // anything at all, mostly clamped
         r = make_req($urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), $urandom());
      end else if (kind < 6) begin
         // modest quaternion, scale at most about two: rarely clamps
         r = make_req($urandom(), $urandom(), $urandom(),
                      srand(12000), srand(12000), srand(12000), srand(12000));
      end else if (kind < 8) begin
         // small vector, so the rounding decides the result
         r = make_req(srand(64), srand(64), srand(64),
                      $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
         // quaternion mostly about one axis, of random scale, with a little jitter
         axis = $urandom_range(0, 2);
         foreach (q[i]) q[i] = srand(200);
         q[axis] = srand(16384);
         q[3]    = srand(16384);
         r = make_req($urandom(), $urandom(), $urandom(), q[0], q[1], q[2], q[3]);
      end
      return r;
   endfunction

   // Present one item, after a random gap when the current burst has run out
   task automatic drive_item(input rot_req_type r);
      int gap;
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_if.valid  <= 1'b1;
      req_if.vec_x  <= r.vec_x;
      req_if.vec_y  <= r.vec_y;
      req_if.vec_z  <= r.vec_z;
      req_if.quat_x <= r.quat_x;
      req_if.quat_y <= r.quat_y;
      req_if.quat_z <= r.quat_z;
      req_if.quat_w <= r.quat_w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Hold the sender off until every outstanding item has come back
   task automatic drain_pipeline();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (rot_check.pending() != 0);
   endtask

   initial begin
      rot_req_type directed [$];
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.vec_x  = '0;
      req_if.vec_y  = '0;
      req_if.vec_z  = '0;
      req_if.quat_x = '0;
      req_if.quat_y = '0;
      req_if.quat_z = '0;
      req_if.quat_w = '0;

      // all zero, and zero quaternion on a full-scale vector
      directed.push_back(make_req(0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_req(32767, -32768, 12345, 0, 0, 0, 0));
      // identity on the vector extremes
      directed.push_back(make_req(32767, -32768, 0, 0, 0, 0, 16384));
      directed.push_back(make_req(-32768, 32767, -1, 0, 0, 0, 16384));
      // quarter turns about z and x, half turn about y
      directed.push_back(make_req(1000, 0, 0, 0, 0, 11585, 11585));
      directed.push_back(make_req(0, 1000, -500, 11585, 0, 0, 11585));
      directed.push_back(make_req(300, -200, 100, 0, 16384, 0, 0));
      // non-unit quaternion scales the vector by about four
      directed.push_back(make_req(100, 200, 300, 0, 0, 0, 32767));
      // quaternion extremes: heavy clamping either way, then on a zero vector
      directed.push_back(make_req(32767, 32767, 32767, -32768, -32768, -32768, -32768));
      directed.push_back(make_req(-32768, -32768, -32768, 32767, 32767, 32767, 32767));
      directed.push_back(make_req(0, 0, 0, -32768, -32768, -32768, -32768));
      // only one component clamped
      directed.push_back(make_req(0, 0, 20000, 32767, 0, 0, 32767));
      directed.push_back(make_req(0, 32767, 0, 32767, 0, 0, 32767));
      // a quarter of the vector: exact ties and values either side of them
      directed.push_back(make_req(1, 0, 0, 0, 0, 0, 8192));
      directed.push_back(make_req(2, 0, 0, 0, 0, 0, 8192));
      directed.push_back(make_req(-2, 0, 0, 0, 0, 0, 8192));
      directed.push_back(make_req(0, -3, 6, 0, 0, 0, 8192));
      // tiny quaternion on full-scale vectors
      directed.push_back(make_req(-32768, 32767, -32768, 1, -1, 1, 1));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) drive_item(directed[i]);
      drain_pipeline();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         drive_item(random_req());
         if (n % 500 == 499) drain_pipeline();
      end

      drain_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (rot_check.mismatches == 0 && rot_check.pending() == 0) begin
         $display("PASS quaternion_vector_rotate");
      end else begin
         $display("FAIL quaternion_vector_rotate");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/qvr_pkg.sv
rtl/qvr_if.sv
rtl/qvr_qv_mul.sv
rtl/qvr_pq_mul.sv
rtl/qvr_round_sat.sv
rtl/quaternion_vector_rotate.sv
tb/sv/tb_top.sv
